>>> rtl/core/shkm_pkg.sv
`default_nettype none

package shkm_pkg;

	localparam int ENTRIES    = 16;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	// fixed field widths of the ports
	localparam int HASH_W     = 30;
	localparam int CHAR_W     = 7;
	localparam int RVAL_W     = 32;
	localparam int NVAL_W     = 32;
	localparam int COUNT_W    = 5;
	localparam int STATUS_W   = 2;

	localparam int MULT_W     = 8;
	localparam int STEP_W     = $clog2(MULT_W + 1);

	localparam logic [HASH_W-1:0] HASH_MOD  = 30'd1000000009;
	localparam logic [MULT_W-1:0] HASH_BASE = 8'd131;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_STORE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	// request travelling down the table chain
	typedef struct packed {
		logic                  vld;
		logic [HASH_W-1:0]     hash;
		logic                  act;
		logic [VALUE_BITS-1:0] wval;
		logic                  hit;
		logic                  app;
		logic [VALUE_BITS-1:0] rval;
	} tok_t;

	// (a + b) mod HASH_MOD for a, b below the modulus
	function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b);
		logic [HASH_W:0] s;
		logic [HASH_W:0] m;
		begin
			s = {1'b0, a} + {1'b0, b};
			m = {1'b0, HASH_MOD};
			if (s >= m) begin
				s = s - m;
			end
			return s[HASH_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/shkm_hasher.sv
`default_nettype none

module shkm_hasher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          act,
	input  wire logic [shkm_pkg::CHAR_W-1:0]   key_char,
	input  wire logic                          key_last,
	input  wire logic [shkm_pkg::NVAL_W-1:0]   wval,
	output logic                               idle,
	output shkm_pkg::tok_t                     tok
);
	import shkm_pkg::*;

	logic                  run_q;
	logic [STEP_W-1:0]     step_q;
	logic [HASH_W-1:0]     hash_q;
	logic [HASH_W-1:0]     pow_q;
	tok_t                  tok_q;

	logic [HASH_W-1:0]     accc_q;
	logic [HASH_W-1:0]     accb_q;
	logic [MULT_W-1:0]     mc_q;
	logic [MULT_W-1:0]     mb_q;
	logic                  last_q;
	logic                  act_q;
	logic [VALUE_BITS-1:0] wval_q;

	logic                  fin;
	logic [HASH_W-1:0]     accc_nxt;
	logic [HASH_W-1:0]     accb_nxt;
	logic [HASH_W-1:0]     hash_nxt;

	assign fin  = run_q && (step_q == STEP_W'(MULT_W));
	assign idle = !run_q;
	assign tok  = tok_q;

	// MSB-first shift-and-add, reduced at every bit
	always_comb begin
		accc_nxt = mod_add(mod_add(accc_q, accc_q), mc_q[MULT_W-1] ? pow_q : '0);
		accb_nxt = mod_add(mod_add(accb_q, accb_q), mb_q[MULT_W-1] ? pow_q : '0);
		hash_nxt = mod_add(hash_q, accc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			hash_q <= '0;
			pow_q  <= HASH_W'(1);
			tok_q  <= '0;
		end else begin
			tok_q.vld <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (fin) begin
				run_q <= 1'b0;
				if (last_q) begin
					hash_q     <= '0;
					pow_q      <= HASH_W'(1);
					tok_q.vld  <= 1'b1;
					tok_q.hash <= hash_nxt;
					tok_q.act  <= act_q;
					tok_q.wval <= wval_q;
					tok_q.hit  <= 1'b0;
					tok_q.app  <= 1'b0;
					tok_q.rval <= '0;
				end else begin
					hash_q <= hash_nxt;
					pow_q  <= accb_q;
				end
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			accc_q <= '0;
			accb_q <= '0;
			mc_q   <= MULT_W'(key_char) + MULT_W'(1);
			mb_q   <= HASH_BASE;
			last_q <= key_last;
			act_q  <= act;
			wval_q <= VALUE_BITS'(wval);
		end else if (run_q && !fin) begin
			accc_q <= accc_nxt;
			accb_q <= accb_nxt;
			mc_q   <= mc_q << 1;
			mb_q   <= mb_q << 1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/shkm_cell.sv
`default_nettype none

module shkm_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [shkm_pkg::IDX_W-1:0]  index,
	input  wire logic [shkm_pkg::CNT_W-1:0]  count,
	input  wire shkm_pkg::tok_t              tok_in,
	output shkm_pkg::tok_t                   tok_s1
);
	import shkm_pkg::*;

	logic [HASH_W-1:0]     hash_q;
	logic [VALUE_BITS-1:0] val_q;

	logic open_tok;
	logic used;
	logic match;
	logic app;
	tok_t tok_nxt;

	always_comb begin
		open_tok = tok_in.vld && !tok_in.hit && !tok_in.app;
		used     = CNT_W'(index) < count;
		match    = open_tok && used && (hash_q == tok_in.hash);
		// the first free slot sits right after every used one
		app      = open_tok && (tok_in.act == ACT_STORE) && (CNT_W'(index) == count);
		tok_nxt  = tok_in;
		tok_nxt.hit = tok_in.hit | match;
		tok_nxt.app = tok_in.app | app;
		if (match && (tok_in.act == ACT_LOOKUP)) begin
			tok_nxt.rval = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (app) begin
			hash_q <= tok_in.hash;
			val_q  <= tok_in.wval;
		end else if (match && (tok_in.act == ACT_STORE)) begin
			val_q <= tok_in.wval;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/string_hash_keyed_map.sv
`default_nettype none

// Keyed table addressed by a polynomial string hash. Key characters arrive one
// word each; every character goes through the hash unit as 8 bit-serial steps
// of a modular multiply in the one-bit-per-cycle multiplier, then the hash add.
// The word carrying the last character then sends a request down a chain of
// ENTRIES table cells, one cell per cycle. Characters of the next key are
// taken while a request is in the chain; the next last character waits until
// the chain is empty and the previous result has been taken. Entries match on
// the hash alone; status is 0 for found or stored, 1 for a lookup that misses,
// 2 for a store dropped by a full table.
module string_hash_keyed_map (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            action,
	input  wire logic [shkm_pkg::CHAR_W-1:0]     key_char,
	input  wire logic                            key_last,
	input  wire logic [shkm_pkg::NVAL_W-1:0]     new_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [shkm_pkg::STATUS_W-1:0]        status,
	output logic [shkm_pkg::RVAL_W-1:0]          read_value,
	output logic [shkm_pkg::HASH_W-1:0]          key_hash,
	output logic [shkm_pkg::COUNT_W-1:0]         entry_count
);
	import shkm_pkg::*;

	tok_t                tok_w [ENTRIES+1];
	logic [ENTRIES-1:0]  cell_vld;
	logic                hasher_idle;
	logic                start;
	logic                busy_q;
	logic                chain_busy;
	logic                out_valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                exit_vld;
	tok_t                exit_tok;
	logic [STATUS_W-1:0] status_nxt;

	assign chain_busy = busy_q | tok_w[0].vld;
	assign in_ready   = hasher_idle && (!key_last || (!chain_busy && !out_valid_q));
	assign start      = in_valid && in_ready;
	assign exit_tok   = tok_w[ENTRIES];
	assign exit_vld   = exit_tok.vld;
	assign out_valid  = out_valid_q;

	shkm_hasher u_hasher (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.act      (action),
		.key_char (key_char),
		.key_last (key_last),
		.wval     (new_value),
		.idle     (hasher_idle),
		.tok      (tok_w[0])
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		shkm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.index  (IDX_W'(i)),
			.count  (count_q),
			.tok_in (tok_w[i]),
			.tok_s1 (tok_w[i+1])
		);
		assign cell_vld[i] = tok_w[i+1].vld;
	end

	always_comb begin
		count_nxt = count_q + CNT_W'(exit_tok.app);
		if (exit_tok.hit || exit_tok.app) begin
			status_nxt = ST_OK;
		end else if (exit_tok.act == ACT_STORE) begin
			status_nxt = ST_FULL;
		end else begin
			status_nxt = ST_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (tok_w[0].vld) begin
				busy_q <= 1'b1;
			end else if (exit_vld) begin
				busy_q <= 1'b0;
			end
			if (exit_vld) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_vld) begin
			status      <= status_nxt;
			read_value  <= RVAL_W'(exit_tok.rval);
			key_hash    <= exit_tok.hash;
			entry_count <= COUNT_W'(count_nxt);
		end
	end

	// a result never lands on one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		exit_vld |-> !out_valid_q)
		else $error("result overwrote a pending word");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_vld))
		else $error("more than one request in the table chain");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		exit_vld && (status_nxt == ST_FULL) |-> count_q == CNT_W'(ENTRIES))
		else $error("store dropped while the table had room");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!exit_vld |=> $stable(count_q))
		else $error("entry count moved without a request");

endmodule

`default_nettype wire
